### src/mld_pkg.sv
// package for the magic/length deframer: frame constants and result record
// no dependencies
`default_nettype none

package mld_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned FIELD_LIMIT = 1024;
  localparam int unsigned LEN_LIMIT_I = (MAX_PAYLOAD < FIELD_LIMIT) ? MAX_PAYLOAD : FIELD_LIMIT;

  localparam logic [15:0] LEN_LIMIT   = 16'(LEN_LIMIT_I);
  localparam logic [7:0]  FRAME_MAGIC = 8'hA5;

  localparam int unsigned POS_W = 11;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned IDX_W = 10;

  // byte position codes; payload positions start at POS_PAYLOAD
  localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(4);

  typedef struct packed {
    logic [7:0]       frame_type;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [LEN_W-1:0] frame_length;
    logic             empty_frame;
    logic             last;
    logic             dropped;
  } result_t;

endpackage

`default_nettype wire

### src/mld_if.sv
// valid/ready channel interfaces for the deframer input bytes and results
// depends on mld_pkg
`default_nettype none

interface mld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mld_out_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     frame_type;
  logic [7:0]                     payload_byte;
  logic [mld_pkg::IDX_W-1:0]      payload_index;
  logic [mld_pkg::LEN_W-1:0]      frame_length;
  logic                           empty_frame;
  logic                           last;
  logic                           dropped;

  modport source (output valid, output frame_type, output payload_byte, output payload_index,
                  output frame_length, output empty_frame, output last, output dropped,
                  input ready);
  modport sink   (input valid, input frame_type, input payload_byte, input payload_index,
                  input frame_length, input empty_frame, input last, input dropped,
                  output ready);
endinterface

`default_nettype wire

### src/magic_length_deframer.sv
// magic/length prefixed frame deframer, byte in, at most one result beat out per byte
// depends on mld_pkg, mld_in_if, mld_out_if
//
//   channel | direction | beat
//   --------+-----------+-----------------------------------------------------------
//   in_if   | sink      | rx_byte
//   out_if  | source    | frame_type, payload_byte, payload_index, frame_length,
//           |           | empty_frame, last, dropped
//
// one byte per cycle while in_if.ready is high: the header/payload decode is one
// level of logic on the position, type and length registers, and its result lands
// in the output register; a second (skid) register takes one result while the
// output beat is stalled; in_if.ready drops only while the skid register is full
// rst_n (synchronous, active low) returns to hunting for the magic byte and
// empties both result registers
`default_nettype none

module magic_length_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mld_in_if.sink           in_if,
  mld_out_if.source        out_if
);
  import mld_pkg::*;

  // frame tracking state
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [7:0]       type_r,   type_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;

  // output and skid registers
  result_t out_r,  out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  // decode of the current byte
  result_t          res;
  logic             has_res;
  logic             in_acc;
  logic             out_pop;
  logic [15:0]      len_full;
  logic [POS_W-1:0] idx;
  logic             fin;

  assign in_if.ready = !skid_valid_r;
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_pop     = out_valid_r && out_if.ready;

  assign len_full = {in_if.rx_byte, len_lo_r};
  assign idx      = pos_r - POS_PAYLOAD;
  // last payload byte once index + 1 reaches the declared length
  assign fin      = ({1'b0, idx} + (POS_W+1)'(1)) >= {1'b0, len_r};

  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    has_res    = 1'b0;
    res        = '0;
    res.frame_type = type_r;

    case (pos_r)
      POS_HUNT: begin
        // anything but the magic byte is dropped on the floor
        if (in_if.rx_byte == FRAME_MAGIC) begin
          pos_nxt = POS_TYPE;
        end
      end
      POS_TYPE: begin
        type_nxt = in_if.rx_byte;
        pos_nxt  = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        len_lo_nxt = in_if.rx_byte;
        pos_nxt    = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        if (len_full > LEN_LIMIT) begin
          // oversize frame: report and go back to hunting
          has_res     = 1'b1;
          res.dropped = 1'b1;
          pos_nxt     = POS_HUNT;
        end else if (len_full == 16'd0) begin
          // zero-length frame: single empty result, marked last
          has_res         = 1'b1;
          res.empty_frame = 1'b1;
          res.last        = 1'b1;
          len_nxt         = '0;
          pos_nxt         = POS_HUNT;
        end else begin
          len_nxt = len_full[LEN_W-1:0];
          pos_nxt = POS_PAYLOAD;
        end
      end
      default: begin
        // payload byte, passed straight through
        has_res           = 1'b1;
        res.payload_byte  = in_if.rx_byte;
        res.payload_index = idx[IDX_W-1:0];
        res.frame_length  = len_r;
        res.last          = fin;
        pos_nxt           = fin ? POS_HUNT : pos_r + POS_W'(1);
      end
    endcase
  end

  // output register with one-deep skid
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      // no new beat can arrive while the skid is full
      if (out_pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc && has_res) begin
      if (!out_valid_r || out_pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_HUNT;
      type_r       <= '0;
      len_lo_r     <= '0;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_r    <= pos_nxt;
        type_r   <= type_nxt;
        len_lo_r <= len_lo_nxt;
        len_r    <= len_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.frame_type    = out_r.frame_type;
  assign out_if.payload_byte  = out_r.payload_byte;
  assign out_if.payload_index = out_r.payload_index;
  assign out_if.frame_length  = out_r.frame_length;
  assign out_if.empty_frame   = out_r.empty_frame;
  assign out_if.last          = out_r.last;
  assign out_if.dropped       = out_r.dropped;

endmodule

`default_nettype wire

### src/mld_checker.sv
// port-level checks for magic_length_deframer, bound to the top level
// depends on mld_pkg
`default_nettype none

module mld_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [7:0]                frame_type,
  input wire logic [7:0]                payload_byte,
  input wire logic [mld_pkg::IDX_W-1:0] payload_index,
  input wire logic [mld_pkg::LEN_W-1:0] frame_length,
  input wire logic                      empty_frame,
  input wire logic                      last,
  input wire logic                      dropped
);
  import mld_pkg::*;

  // a dropped beat carries nothing but the type
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> !last && !empty_frame && payload_byte == 8'd0
                             && payload_index == '0 && frame_length == '0)
    else $error("dropped beat carries payload fields");

  // an empty frame is a single last beat with no length
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_frame |-> last && !dropped && frame_length == '0)
    else $error("empty-frame beat malformed");

  // payload beats stay inside the declared length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !dropped && !empty_frame |->
      frame_length != '0 && {1'b0, payload_index} < frame_length)
    else $error("payload index outside declared length");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte)
                                && $stable(payload_index) && $stable(last))
    else $error("stalled result beat changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind magic_length_deframer mld_checker u_mld_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .frame_type    (out_if.frame_type),
  .payload_byte  (out_if.payload_byte),
  .payload_index (out_if.payload_index),
  .frame_length  (out_if.frame_length),
  .empty_frame   (out_if.empty_frame),
  .last          (out_if.last),
  .dropped       (out_if.dropped)
);

`default_nettype wire
